// ===== sv/sed_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and byte classification for the string escape decoder.
// No dependencies; used by sed_front, sed_back and the top level.
package sed_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ACC_W       = 32;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_UE     = 8'h45;

  localparam logic [7:0] VAL_BEL = 8'd7;
  localparam logic [7:0] VAL_BS  = 8'd8;
  localparam logic [7:0] VAL_HT  = 8'd9;
  localparam logic [7:0] VAL_LF  = 8'd10;
  localparam logic [7:0] VAL_VT  = 8'd11;
  localparam logic [7:0] VAL_FF  = 8'd12;
  localparam logic [7:0] VAL_CR  = 8'd13;
  localparam logic [7:0] VAL_ESC = 8'd27;

  // Classified input byte, as it travels through the queue
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_piece;
    logic       is_bslash;
    logic       is_x;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] esc_val;
    logic       esc_ns;
  } item_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       run_last;
    logic       piece_end;
    logic       no_digits_error;
    logic       value_too_large;
    logic       nonstandard_escape;
  } result_t;

  function automatic item_t classify(input logic [7:0] b, input logic e);
    item_t it;
    logic  dec, lo, up;
    dec = (b >= CH_ZERO) && (b <= CH_NINE);
    lo  = (b >= CH_LA) && (b <= CH_LF);
    up  = (b >= CH_UA) && (b <= CH_UF);
    it.in_byte      = b;
    it.end_of_piece = e;
    it.is_bslash    = (b == CH_BSLASH);
    it.is_x         = (b == CH_X);
    it.is_oct       = (b >= CH_ZERO) && (b <= CH_SEVEN);
    it.is_hex       = dec || lo || up;
    // letters a-f and A-F share a low nibble of 1..6
    it.hex_val      = dec ? b[3:0] : (b[3:0] + 4'd9);
    it.esc_val      = b;
    it.esc_ns       = 1'b0;
    unique case (b)
      CH_BSLASH, CH_QUOTE, CH_DQUOTE, CH_QMARK: it.esc_val = b;
      CH_LA: it.esc_val = VAL_BEL;
      CH_LB: it.esc_val = VAL_BS;
      CH_LF: it.esc_val = VAL_FF;
      CH_LN: it.esc_val = VAL_LF;
      CH_LR: it.esc_val = VAL_CR;
      CH_LT: it.esc_val = VAL_HT;
      CH_LV: it.esc_val = VAL_VT;
      CH_LE, CH_UE: begin
        it.esc_val = VAL_ESC;
        it.esc_ns  = 1'b1;
      end
      default: it.esc_ns = 1'b1;
    endcase
    return it;
  endfunction

endpackage

// ===== sv/sed_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the string escape decoder: body bytes in, decoded characters out.
// No dependencies.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_piece;

  modport source (output valid, output in_byte, output end_of_piece, input ready);
  modport sink (input valid, input in_byte, input end_of_piece, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_value;
  logic       run_last;
  logic       piece_end;
  logic       no_digits_error;
  logic       value_too_large;
  logic       nonstandard_escape;

  modport source (output valid, output char_value, output run_last, output piece_end,
                  output no_digits_error, output value_too_large,
                  output nonstandard_escape, input ready);
  modport sink (input valid, input char_value, input run_last, input piece_end,
                input no_digits_error, input value_too_large,
                input nonstandard_escape, output ready);
endinterface

// ===== sv/string_escape_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the string escape decoder: joins the classifying front end and the decoding back end.
// Depends on sed_pkg, sed_if, sed_front and sed_back.
//
// Decodes the body bytes of string literals, one byte per transaction, into characters, with
// C escapes resolved and error flags per character. A byte is taken every cycle while the
// two-entry front queue has room; a byte that yields one character or none keeps the back end
// at one byte per cycle while the output is taken. A byte that yields two characters (a numeric
// escape flushed by the byte after it, or a hex escape with no digits) has its second character
// held in the holding stage, and no new byte is taken until it reaches the output register.
// There is no clearing pass; the block accepts bytes straight after reset.
module string_escape_decoder (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    byte_ch,
  sed_out_if.source char_ch
);
  import sed_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  sed_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .char_ch (char_ch)
  );

  // a character that ends a piece is always the last one of its byte
  a_piece_end_last: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid && char_ch.piece_end |-> char_ch.run_last)
    else $error("piece end on a character that is not the last of its byte");

  // an escape with no digits yields zero and carries no other flag
  a_no_digits_clean: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid && char_ch.no_digits_error |->
      char_ch.char_value == 8'd0 && !char_ch.value_too_large && !char_ch.nonstandard_escape)
    else $error("missing-digit error with a value or another flag");

  // numeric overflow and a nonstandard escape never meet on one character
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid && char_ch.value_too_large |-> !char_ch.nonstandard_escape)
    else $error("overflow flagged on a nonstandard escape");

endmodule

// ===== sv/sed_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each accepted byte and holds it in a short queue for the back end.
// Depends on sed_pkg and sed_in_if.
module sed_front (
  input  logic           clk,
  input  logic           rst,
  sed_in_if.sink         byte_ch,
  output logic           q_valid,
  input  logic           q_ready,
  output sed_pkg::item_t q_item
);
  import sed_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign byte_ch.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push          = byte_ch.valid && byte_ch.ready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= classify(byte_ch.in_byte, byte_ch.end_of_piece);
        wr_ptr          <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/sed_back.sv =====
`timescale 1ns / 1ps
// Back end: escape state machine, output register and a second-result holding stage.
// Depends on sed_pkg and sed_out_if.
module sed_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  sed_pkg::item_t q_item,
  sed_out_if.source      char_ch
);
  import sed_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BACKSLASH,
    S_OCTAL,
    S_HEX_START,
    S_HEX
  } mode_t;

  mode_t             mode, mode_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [1:0]        cnt, cnt_next;
  logic              sticky, sticky_next;
  logic [1:0]        nres;
  result_t           r0, r1;
  result_t           out_data, pend_data;
  logic              out_valid, pend_valid;
  logic              load;
  logic              take;

  logic [8:0]        oct_acc;
  logic [ACC_W-1:0]  hex_acc;
  logic              hex_ovf;
  logic              plain_emit;
  result_t           plain_res;
  mode_t             plain_mode;

  assign load    = !out_valid || char_ch.ready;
  assign take    = q_valid && load && !pend_valid;
  assign q_ready = load && !pend_valid;

  assign char_ch.valid              = out_valid;
  assign char_ch.char_value         = out_data.char_value;
  assign char_ch.run_last           = out_data.run_last;
  assign char_ch.piece_end          = out_data.piece_end;
  assign char_ch.no_digits_error    = out_data.no_digits_error;
  assign char_ch.value_too_large    = out_data.value_too_large;
  assign char_ch.nonstandard_escape = out_data.nonstandard_escape;

  always_comb begin
    oct_acc = {acc[5:0], q_item.in_byte[2:0]};
    hex_acc = {acc[ACC_W-5:0], q_item.hex_val};
    hex_ovf = sticky || (|acc[ACC_W-1:ACC_W-4]);

    // a byte outside an escape: a trailing backslash is an error, another opens an escape, any other byte passes
    plain_emit = !q_item.is_bslash || q_item.end_of_piece;
    plain_res  = '0;
    if (q_item.is_bslash) begin
      plain_res.piece_end       = 1'b1;
      plain_res.no_digits_error = 1'b1;
    end else begin
      plain_res.char_value = q_item.in_byte;
      plain_res.piece_end  = q_item.end_of_piece;
    end
    plain_mode = (q_item.is_bslash && !q_item.end_of_piece) ? S_BACKSLASH : S_IDLE;

    mode_next   = mode;
    acc_next    = acc;
    cnt_next    = cnt;
    sticky_next = sticky;
    nres        = 2'd0;
    r0          = '0;
    r1          = '0;

    unique case (mode)
      S_IDLE: begin
        mode_next = plain_mode;
        acc_next  = '0;
        cnt_next  = '0;
        sticky_next = 1'b0;
        if (plain_emit) begin
          nres = 2'd1;
          r0   = plain_res;
        end
      end
      S_BACKSLASH: begin
        mode_next   = S_IDLE;
        acc_next    = '0;
        cnt_next    = '0;
        sticky_next = 1'b0;
        if (q_item.is_x) begin
          if (q_item.end_of_piece) begin
            nres              = 2'd1;
            r0.piece_end       = 1'b1;
            r0.no_digits_error = 1'b1;
          end else begin
            mode_next = S_HEX_START;
          end
        end else if (q_item.is_oct) begin
          if (q_item.end_of_piece) begin
            nres          = 2'd1;
            r0.char_value = {5'd0, q_item.in_byte[2:0]};
            r0.piece_end  = 1'b1;
          end else begin
            acc_next  = ACC_W'(q_item.in_byte[2:0]);
            cnt_next  = 2'd1;
            mode_next = S_OCTAL;
          end
        end else begin
          nres                  = 2'd1;
          r0.char_value         = q_item.esc_val;
          r0.piece_end          = q_item.end_of_piece;
          r0.nonstandard_escape = q_item.esc_ns;
        end
      end
      S_OCTAL: begin
        if (q_item.is_oct) begin
          // third digit or end of piece closes the escape
          if (q_item.end_of_piece || cnt == 2'd2) begin
            nres               = 2'd1;
            r0.char_value      = oct_acc[7:0];
            r0.piece_end       = q_item.end_of_piece;
            r0.value_too_large = oct_acc[8];
            mode_next          = S_IDLE;
            acc_next           = '0;
            cnt_next           = '0;
          end else begin
            acc_next = ACC_W'(oct_acc);
            cnt_next = cnt + 2'd1;
          end
        end else begin
          r0.char_value      = acc[7:0];
          r0.value_too_large = |acc[ACC_W-1:8];
          nres               = plain_emit ? 2'd2 : 2'd1;
          r1                 = plain_res;
          mode_next          = plain_mode;
          acc_next           = '0;
          cnt_next           = '0;
        end
      end
      S_HEX_START: begin
        if (q_item.is_hex) begin
          sticky_next = 1'b0;
          if (q_item.end_of_piece) begin
            nres          = 2'd1;
            r0.char_value = {4'd0, q_item.hex_val};
            r0.piece_end  = 1'b1;
            mode_next     = S_IDLE;
            acc_next      = '0;
          end else begin
            acc_next  = ACC_W'(q_item.hex_val);
            mode_next = S_HEX;
          end
        end else begin
          r0.no_digits_error = 1'b1;
          nres               = plain_emit ? 2'd2 : 2'd1;
          r1                 = plain_res;
          mode_next          = plain_mode;
          acc_next           = '0;
          sticky_next        = 1'b0;
        end
      end
      S_HEX: begin
        if (q_item.is_hex) begin
          if (q_item.end_of_piece) begin
            nres               = 2'd1;
            r0.char_value      = hex_acc[7:0];
            r0.piece_end       = 1'b1;
            r0.value_too_large = hex_ovf || (|hex_acc[ACC_W-1:8]);
            mode_next          = S_IDLE;
            acc_next           = '0;
            sticky_next        = 1'b0;
          end else begin
            acc_next    = hex_acc;
            sticky_next = hex_ovf;
          end
        end else begin
          r0.char_value      = acc[7:0];
          r0.value_too_large = sticky || (|acc[ACC_W-1:8]);
          nres               = plain_emit ? 2'd2 : 2'd1;
          r1                 = plain_res;
          mode_next          = plain_mode;
          acc_next           = '0;
          sticky_next        = 1'b0;
        end
      end
      default: begin
        mode_next   = S_IDLE;
        acc_next    = '0;
        cnt_next    = '0;
        sticky_next = 1'b0;
      end
    endcase

    // end of piece always drops any escape in progress
    if (q_item.end_of_piece) begin
      mode_next   = S_IDLE;
      acc_next    = '0;
      cnt_next    = '0;
      sticky_next = 1'b0;
    end

    r0.run_last = (nres == 2'd1);
    r1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= S_IDLE;
      acc        <= '0;
      cnt        <= '0;
      sticky     <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_data   <= pend_data;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (take) begin
        mode      <= mode_next;
        acc       <= acc_next;
        cnt       <= cnt_next;
        sticky    <= sticky_next;
        out_data  <= r0;
        out_valid <= (nres != 2'd0);
        // hold the second result until the first has gone
        pend_data  <= r1;
        pend_valid <= (nres == 2'd2);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/string_escape_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for string_escape_decoder: directed byte table, then random literal pieces.
// Depends on sed_pkg, sed_if and the decoder RTL; predicts characters from typed rows or its model.
module string_escape_decoder_tb;
  import sed_pkg::*;

  localparam int RANDOM_BYTES   = 500;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_OFF_AFTER = 120;
  localparam int HOLD_OFF_LEN   = 150;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       eop;
    logic       typed;
    result_t    want;
  } body_byte_t;

  typedef enum logic [2:0] {DM_IDLE, DM_BSLASH, DM_OCTAL, DM_HEX_START, DM_HEX} decode_mode_e;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_EVERY_THIRD} sink_pattern_e;

  localparam result_t NO_RESULT = '0;

  // Fields of want: char_value, run_last, piece_end, no_digits_error, value_too_large,
  // nonstandard_escape. Rows without a typed result are checked against the decoder model.
  localparam body_byte_t DIRECTED_BYTES [26] = '{
    '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'hFF,     1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{CH_X,      1'b0, 1'b0, NO_RESULT},
    '{"z",       1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{"1",       1'b0, 1'b0, NO_RESULT},
    '{"2",       1'b0, 1'b0, NO_RESULT},
    '{"3",       1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{CH_SEVEN,  1'b0, 1'b0, NO_RESULT},
    '{CH_SEVEN,  1'b0, 1'b0, NO_RESULT},
    '{CH_SEVEN,  1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{"8",       1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{CH_UE,     1'b0, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{CH_X,      1'b0, 1'b0, NO_RESULT},
    '{"1",       1'b0, 1'b0, NO_RESULT},
    '{CH_ZERO,   1'b0, 1'b0, NO_RESULT},
    '{CH_ZERO,   1'b1, 1'b0, NO_RESULT},
    '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
    '{"4",       1'b0, 1'b0, NO_RESULT},
    '{"q",       1'b1, 1'b0, NO_RESULT}
  };

  localparam logic [7:0] SIMPLE_ESC [13] = '{
    CH_BSLASH, CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_LA, CH_LB, CH_LF,
    CH_LN, CH_LR, CH_LT, CH_LV, CH_LE, CH_UE
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sed_in_if  byte_ch ();
  sed_out_if char_ch ();

  string_escape_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .char_ch (char_ch)
  );

  // Decoder model state
  decode_mode_e dmode = DM_IDLE;
  logic [31:0]  acc = '0;
  logic [1:0]   oct_cnt = '0;
  logic         sticky = 1'b0;
  result_t      step_chars [$];

  body_byte_t body_bytes [$];
  result_t    expected_chars [$];
  body_byte_t cur_byte;
  result_t    got_char;
  result_t    want_char;

  int n_errors = 0;
  int n_accepted = 0;
  int n_pieces = 0;
  int n_chars = 0;
  int n_nodig = 0;
  int n_big = 0;
  int n_nonstd = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_LA && b <= CH_LF) return int'(b - CH_LA) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  task automatic clear_escape();
    dmode   = DM_IDLE;
    acc     = '0;
    oct_cnt = '0;
    sticky  = 1'b0;
  endtask

  task automatic add_char(input logic [7:0] v, input logic pe, input logic nd,
                          input logic big, input logic ns);
    step_chars.push_back('{v, 1'b0, pe, nd, big, ns});
  endtask

  task automatic flush_numeric(input logic pe);
    add_char(acc[7:0], pe, 1'b0, sticky || (acc > 32'hFF), 1'b0);
    clear_escape();
  endtask

  task automatic decode_literal(input logic [7:0] b, input logic eop);
    if (b == CH_BSLASH) begin
      if (eop) add_char(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
      else dmode = DM_BSLASH;
    end else begin
      add_char(b, eop, 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic decode_escape(input logic [7:0] b, input logic eop);
    logic [7:0] v;
    logic       ns;
    clear_escape();
    if (b == CH_X) begin
      if (eop) add_char(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
      else dmode = DM_HEX_START;
    end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
      acc     = 32'(b[2:0]);
      oct_cnt = 2'd1;
      dmode   = DM_OCTAL;
      if (eop) flush_numeric(1'b1);
    end else begin
      v  = b;
      ns = 1'b0;
      case (b)
        CH_BSLASH, CH_QUOTE, CH_DQUOTE, CH_QMARK: v = b;
        CH_LA: v = VAL_BEL;
        CH_LB: v = VAL_BS;
        CH_LF: v = VAL_FF;
        CH_LN: v = VAL_LF;
        CH_LR: v = VAL_CR;
        CH_LT: v = VAL_HT;
        CH_LV: v = VAL_VT;
        CH_LE, CH_UE: begin
          v  = VAL_ESC;
          ns = 1'b1;
        end
        default: ns = 1'b1;
      endcase
      add_char(v, eop, 1'b0, 1'b0, ns);
    end
  endtask

  // Work out the characters one accepted byte produces, leaving them in step_chars
  task automatic decode_byte(input logic [7:0] b, input logic eop);
    int d;
    step_chars.delete();
    d = nibble_of(b);
    case (dmode)
      DM_BSLASH: decode_escape(b, eop);
      DM_OCTAL: begin
        if (b >= CH_ZERO && b <= CH_SEVEN && oct_cnt < 2'd3) begin
          acc     = {acc[28:0], b[2:0]};
          oct_cnt = oct_cnt + 2'd1;
          if (eop || oct_cnt == 2'd3) flush_numeric(eop);
        end else begin
          flush_numeric(1'b0);
          decode_literal(b, eop);
        end
      end
      DM_HEX_START: begin
        if (d >= 0) begin
          acc    = 32'(d);
          sticky = 1'b0;
          dmode  = DM_HEX;
          if (eop) flush_numeric(1'b1);
        end else begin
          add_char(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          clear_escape();
          decode_literal(b, eop);
        end
      end
      DM_HEX: begin
        if (d >= 0) begin
          if (acc[31:28] != 4'h0) sticky = 1'b1;
          acc = {acc[27:0], 4'(d)};
          if (eop) flush_numeric(1'b1);
        end else begin
          flush_numeric(1'b0);
          decode_literal(b, eop);
        end
      end
      default: begin
        clear_escape();
        decode_literal(b, eop);
      end
    endcase
    if (eop) clear_escape();
    if (step_chars.size() != 0) step_chars[step_chars.size() - 1].run_last = 1'b1;
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(int'(CH_ZERO) + v);
    return 8'(($urandom_range(0, 1) ? int'(CH_LA) : int'(CH_UA)) + v - 10);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eop = 1'b0);
    body_bytes.push_back('{b, eop, 1'b0, NO_RESULT});
  endtask

  // Random literal pieces: mostly well-formed escapes with random content, some noise
  task automatic add_random_pieces();
    int n_elems;
    int kind;
    int n_digits;
    logic [7:0] b;
    while (body_bytes.size() < $size(DIRECTED_BYTES) + RANDOM_BYTES) begin
      n_elems = $urandom_range(1, 8);
      for (int i = 0; i < n_elems; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_BSLASH) add_byte(CH_BSLASH);
          add_byte(b);
        end else if (kind < 45) begin
          add_byte(CH_BSLASH);
          add_byte(SIMPLE_ESC[$urandom_range(0, $size(SIMPLE_ESC) - 1)]);
        end else if (kind < 52) begin
          add_byte(CH_BSLASH);
          if ($urandom_range(0, 1)) b = 8'(int'(CH_SEVEN) + $urandom_range(1, 2));
          else b = 8'($urandom_range(0, 255));
          add_byte(b);
        end else if (kind < 70) begin
          add_byte(CH_BSLASH);
          n_digits = $urandom_range(1, 4);
          repeat (n_digits) add_byte(8'(int'(CH_ZERO) + $urandom_range(0, 7)));
          // end some escapes on an 8 or 9
          if ($urandom_range(0, 3) == 0) add_byte(8'(int'(CH_SEVEN) + $urandom_range(1, 2)));
        end else if (kind < 90) begin
          add_byte(CH_BSLASH);
          add_byte(CH_X);
          n_digits = ($urandom_range(0, 2) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 3);
          repeat (n_digits) add_byte(random_hex_char());
        end else if (kind < 95) begin
          // backslash closes the piece
          add_byte(CH_BSLASH);
          break;
        end else begin
          repeat ($urandom_range(1, 3)) begin
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          end
        end
      end
      body_bytes[body_bytes.size() - 1].eop = 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Predict on accepted bytes, then check accepted characters in order
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      cur_byte = body_bytes[n_accepted];
      decode_byte(byte_ch.in_byte, byte_ch.end_of_piece);
      if (cur_byte.typed) expected_chars.push_back(cur_byte.want);
      else foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
      if (byte_ch.end_of_piece) n_pieces++;
      n_accepted++;
    end
    if (!rst && char_ch.valid && char_ch.ready) begin
      got_char = '{char_ch.char_value, char_ch.run_last, char_ch.piece_end,
                   char_ch.no_digits_error, char_ch.value_too_large, char_ch.nonstandard_escape};
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character 0x%0h, nothing outstanding", $time,
                 got_char.char_value);
        n_errors++;
      end else begin
        want_char = expected_chars.pop_front();
        compare_field("char_value", want_char.char_value, got_char.char_value);
        compare_field("run_last", 8'(want_char.run_last), 8'(got_char.run_last));
        compare_field("piece_end", 8'(want_char.piece_end), 8'(got_char.piece_end));
        compare_field("no_digits_error", 8'(want_char.no_digits_error),
                      8'(got_char.no_digits_error));
        compare_field("value_too_large", 8'(want_char.value_too_large),
                      8'(got_char.value_too_large));
        compare_field("nonstandard_escape", 8'(want_char.nonstandard_escape),
                      8'(got_char.nonstandard_escape));
      end
      n_chars++;
      if (got_char.no_digits_error === 1'b1) n_nodig++;
      if (got_char.value_too_large === 1'b1) n_big++;
      if (got_char.nonstandard_escape === 1'b1) n_nonstd++;
    end
  end

  // Receiver: shifting stall patterns, plus one long hold-off to back the block up
  initial begin
    int left;
    int phase;
    sink_pattern_e pattern;
    char_ch.ready = 1'b0;
    left = 0;
    phase = 0;
    pattern = SINK_OPEN;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_cycles == 0 && n_accepted >= HOLD_OFF_AFTER) begin
        char_ch.ready = 1'b0;
        while (hold_off_cycles < HOLD_OFF_LEN) begin
          @(negedge clk);
          hold_off_cycles++;
        end
      end else begin
        if (left == 0) begin
          pattern = sink_pattern_e'($urandom_range(0, 3));
          left = $urandom_range(8, 64);
        end
        left--;
        phase++;
        case (pattern)
          SINK_OPEN:        char_ch.ready = 1'b1;
          SINK_COIN:        char_ch.ready = 1'($urandom_range(0, 1));
          SINK_SPARSE:      char_ch.ready = ($urandom_range(0, 3) == 0);
          SINK_EVERY_THIRD: char_ch.ready = (phase % 3 == 0);
          default:          char_ch.ready = 1'b1;
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles, %0d characters outstanding", $time,
             cycle_count, expected_chars.size());
    $display("Regression FAIL");
    $finish;
  end

  // Sender: directed table then random pieces, in bursts with random gaps
  initial begin
    int idx;
    int burst;
    int gap;
    byte_ch.valid        = 1'b0;
    byte_ch.in_byte      = '0;
    byte_ch.end_of_piece = 1'b0;
    foreach (DIRECTED_BYTES[i]) body_bytes.push_back(DIRECTED_BYTES[i]);
    add_random_pieces();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    idx = 0;
    while (idx < body_bytes.size()) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < body_bytes.size(); k++) begin
        byte_ch.valid        = 1'b1;
        byte_ch.in_byte      = body_bytes[idx].in_byte;
        byte_ch.end_of_piece = body_bytes[idx].eop;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        @(negedge clk);
        idx++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        byte_ch.valid        = 1'b0;
        byte_ch.in_byte      = 8'($urandom_range(0, 255));
        byte_ch.end_of_piece = 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
    byte_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Decoded %0d bytes over %0d literal pieces into %0d characters.",
             n_accepted, n_pieces, n_chars);
    $display("Flags: %0d missing digits, %0d too large, %0d nonstandard; output held %0d cycles.",
             n_nodig, n_big, n_nonstd, hold_off_cycles);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
